@@ rtl/c_source_tokenizer_core_assert.svh @@
// Assertion macros for the C source tokenizer
`ifndef C_SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define C_SOURCE_TOKENIZER_CORE_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define CTOK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// antecedent in this cycle implies consequent in the next cycle
`define CTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

@@ rtl/ctok_pkg.sv @@
// Types and constants shared by the tokenizer modules
`timescale 1ns / 1ps

package ctok_pkg;

    localparam int OFS_W = 32;
    localparam int LEN_W = 16;
    localparam int LIN_W = 24;

    localparam int MAX_TOK = 3;
    localparam int PUSH_W  = 2;
    localparam int QDEPTH  = 4;
    localparam int QIDX_W  = 2;
    localparam int QLVL_W  = 3;

    localparam logic [2:0] KIND_INVALID   = 3'd0;
    localparam logic [2:0] KIND_IDENT     = 3'd1;
    localparam logic [2:0] KIND_NUMBER    = 3'd2;
    localparam logic [2:0] KIND_STRING    = 3'd3;
    localparam logic [2:0] KIND_DIRECTIVE = 3'd4;
    localparam logic [2:0] KIND_PUNCT     = 3'd5;
    localparam logic [2:0] KIND_END       = 3'd6;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [7:0]       punct_code;
        logic [OFS_W-1:0] start_offset;
        logic [LEN_W-1:0] token_length;
        logic [LIN_W-1:0] line_number;
        logic             last_of_run;
    } t_tok;

    typedef struct packed {
        logic [PUSH_W-1:0]        n;
        t_tok [MAX_TOK-1:0]       tok;
    } t_push;

endpackage

@@ rtl/ctok_lexer.sv @@
// Lexer state registers and the per-item token logic
`timescale 1ns / 1ps

module ctok_lexer #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  ctok_pkg::t_in        i_data,
    output ctok_pkg::t_push      o_push
);

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_SLASH     = 4'd1;
    localparam logic [3:0] M_LCOM      = 4'd2;
    localparam logic [3:0] M_LCOM_ESC  = 4'd3;
    localparam logic [3:0] M_BCOM      = 4'd4;
    localparam logic [3:0] M_BCOM_STAR = 4'd5;
    localparam logic [3:0] M_IDENT     = 4'd6;
    localparam logic [3:0] M_NUM_ZERO  = 4'd7;
    localparam logic [3:0] M_NUM_BODY  = 4'd8;
    localparam logic [3:0] M_STR       = 4'd9;
    localparam logic [3:0] M_STR_ESC   = 4'd10;
    localparam logic [3:0] M_DIR       = 4'd11;
    localparam logic [3:0] M_DIR_ESC   = 4'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_USC   = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    logic [3:0]             r_mode,   n_mode;
    logic [OFFSET_BITS-1:0] r_start,  n_start;
    logic [LENGTH_BITS-1:0] r_cnt,    n_cnt;
    logic [LINE_BITS-1:0]   r_sline,  n_sline;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [LINE_BITS-1:0]   r_line,   n_line;
    logic                   r_ended,  n_ended;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic                   redo;
    logic [7:0]             b;
    logic                   is_let, is_dig, is_hex;
    logic [ctok_pkg::PUSH_W-1:0]          nt;
    ctok_pkg::t_tok [ctok_pkg::MAX_TOK-1:0] tk;

    function automatic ctok_pkg::t_tok make_tok(
        input logic [2:0]             kind,
        input logic [7:0]             code,
        input logic [OFFSET_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0] len,
        input logic [LINE_BITS-1:0]   line
    );
        ctok_pkg::t_tok t;
        logic [63:0]    s64;
        logic [63:0]    l64;
        logic [63:0]    n64;
        s64 = 64'(start);
        l64 = 64'(len);
        n64 = 64'(line);
        t.token_kind   = kind;
        t.punct_code   = code;
        t.start_offset = s64[ctok_pkg::OFS_W-1:0];
        t.token_length = l64[ctok_pkg::LEN_W-1:0];
        t.line_number  = n64[ctok_pkg::LIN_W-1:0];
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    assign b       = i_data.text_byte;
    assign pos_inc  = (r_pos == '1) ? r_pos : OFFSET_BITS'(r_pos + 1'b1);
    assign line_inc = (r_line == '1) ? r_line : LINE_BITS'(r_line + 1'b1);
    assign cnt_inc  = (r_cnt == '1) ? r_cnt : LENGTH_BITS'(r_cnt + 1'b1);
    assign is_let   = (b inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]});
    assign is_dig   = (b inside {[CH_ZERO:CH_NINE]});
    assign is_hex   = is_dig || (b inside {[CH_UC_A:CH_UC_F], [CH_LC_A:CH_LC_F]});

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_sline = r_sline;
        n_pos   = r_pos;
        n_line  = r_line;
        n_ended = r_ended;
        redo    = 1'b0;
        nt      = '0;
        tk      = '0;
        if (i_accept && !r_ended) begin
            if (b != CH_NUL) begin
                case (r_mode)
                    M_SLASH: begin
                        if (b == CH_SLASH) begin
                            n_mode = M_LCOM;
                        end else if (b == CH_STAR) begin
                            n_mode = M_BCOM;
                        end else begin
                            tk[nt] = make_tok(ctok_pkg::KIND_PUNCT, CH_SLASH, r_start,
                                              LENGTH_BITS'(1), r_sline);
                            nt     = nt + 1'b1;
                            n_mode = M_IDLE;
                            redo   = 1'b1;
                        end
                    end
                    M_LCOM: begin
                        if (b == CH_BSL) begin
                            n_mode = M_LCOM_ESC;
                        end else if (b == CH_NL) begin
                            n_mode = M_IDLE;
                        end
                    end
                    M_LCOM_ESC: begin
                        n_mode = M_LCOM;
                    end
                    M_BCOM: begin
                        if (b == CH_STAR) begin
                            n_mode = M_BCOM_STAR;
                        end
                    end
                    M_BCOM_STAR: begin
                        if (b == CH_SLASH) begin
                            n_mode = M_IDLE;
                        end else if (b != CH_STAR) begin
                            n_mode = M_BCOM;
                        end
                    end
                    M_IDENT: begin
                        if (is_let || is_dig || b == CH_USC) begin
                            n_cnt = cnt_inc;
                        end else begin
                            tk[nt] = make_tok(ctok_pkg::KIND_IDENT, 8'h00, r_start, r_cnt,
                                              r_sline);
                            nt     = nt + 1'b1;
                            n_mode = M_IDLE;
                            redo   = 1'b1;
                        end
                    end
                    M_NUM_ZERO: begin
                        if (b inside {CH_LC_X, CH_UC_X, CH_LC_B, CH_DOT}) begin
                            n_cnt  = cnt_inc;
                            n_mode = M_NUM_BODY;
                        end else begin
                            tk[nt] = make_tok(ctok_pkg::KIND_NUMBER, 8'h00, r_start, r_cnt,
                                              r_sline);
                            nt     = nt + 1'b1;
                            n_mode = M_IDLE;
                            redo   = 1'b1;
                        end
                    end
                    M_NUM_BODY: begin
                        if (is_hex || b == CH_DOT) begin
                            n_cnt = cnt_inc;
                        end else begin
                            tk[nt] = make_tok(ctok_pkg::KIND_NUMBER, 8'h00, r_start, r_cnt,
                                              r_sline);
                            nt     = nt + 1'b1;
                            n_mode = M_IDLE;
                            redo   = 1'b1;
                        end
                    end
                    M_STR: begin
                        if (b == CH_QUOTE) begin
                            tk[nt] = make_tok(ctok_pkg::KIND_STRING, 8'h00, r_start, r_cnt,
                                              r_sline);
                            nt     = nt + 1'b1;
                            n_mode = M_IDLE;
                        end else begin
                            if (b == CH_BSL) begin
                                n_mode = M_STR_ESC;
                            end
                            n_cnt = cnt_inc;
                        end
                    end
                    M_STR_ESC: begin
                        n_cnt  = cnt_inc;
                        n_mode = M_STR;
                    end
                    M_DIR: begin
                        if (b == CH_NL) begin
                            tk[nt] = make_tok(ctok_pkg::KIND_DIRECTIVE, 8'h00, r_start,
                                              r_cnt, r_sline);
                            nt     = nt + 1'b1;
                            n_mode = M_IDLE;
                        end else begin
                            if (b == CH_BSL) begin
                                n_mode = M_DIR_ESC;
                            end
                            n_cnt = cnt_inc;
                        end
                    end
                    M_DIR_ESC: begin
                        n_cnt  = cnt_inc;
                        n_mode = M_DIR;
                    end
                    default: begin
                        n_mode = M_IDLE;
                        redo   = 1'b1;
                    end
                endcase

                if (redo) begin
                    if (b inside {CH_SP, CH_TAB, CH_NL, CH_CR}) begin
                        n_mode = M_IDLE;
                    end else if (b == CH_SLASH || b == CH_QUOTE || is_let || is_dig
                                 || b == CH_HASH) begin
                        n_start = (b == CH_QUOTE) ? pos_inc : r_pos;
                        n_cnt   = LENGTH_BITS'(1);
                        n_sline = r_line;
                        if (b == CH_SLASH) begin
                            n_mode = M_SLASH;
                        end else if (b == CH_QUOTE) begin
                            n_mode = M_STR;
                        end else if (is_let) begin
                            n_mode = M_IDENT;
                        end else if (b == CH_ZERO) begin
                            n_mode = M_NUM_ZERO;
                        end else if (is_dig) begin
                            n_mode = M_NUM_BODY;
                        end else begin
                            n_mode = M_DIR;
                        end
                    end else if (b >= CH_BANG && b <= CH_TILDE) begin
                        tk[nt] = make_tok(ctok_pkg::KIND_PUNCT, b, r_pos, LENGTH_BITS'(1),
                                          r_line);
                        nt     = nt + 1'b1;
                    end else begin
                        tk[nt] = make_tok(ctok_pkg::KIND_INVALID, 8'h00, r_pos,
                                          LENGTH_BITS'(1), r_line);
                        nt     = nt + 1'b1;
                    end
                end

                n_pos = pos_inc;
                if (b == CH_NL) begin
                    n_line = line_inc;
                end
            end

            if (b == CH_NUL || i_data.final_byte) begin
                case (n_mode)
                    M_SLASH: begin
                        tk[nt] = make_tok(ctok_pkg::KIND_PUNCT, CH_SLASH, n_start,
                                          LENGTH_BITS'(1), n_sline);
                        nt     = nt + 1'b1;
                    end
                    M_IDENT: begin
                        tk[nt] = make_tok(ctok_pkg::KIND_IDENT, 8'h00, n_start, n_cnt,
                                          n_sline);
                        nt     = nt + 1'b1;
                    end
                    M_NUM_ZERO, M_NUM_BODY: begin
                        tk[nt] = make_tok(ctok_pkg::KIND_NUMBER, 8'h00, n_start, n_cnt,
                                          n_sline);
                        nt     = nt + 1'b1;
                    end
                    M_STR, M_STR_ESC: begin
                        tk[nt] = make_tok(ctok_pkg::KIND_STRING, 8'h00, n_start, n_cnt,
                                          n_sline);
                        nt     = nt + 1'b1;
                    end
                    M_DIR, M_DIR_ESC: begin
                        tk[nt] = make_tok(ctok_pkg::KIND_DIRECTIVE, 8'h00, n_start, n_cnt,
                                          n_sline);
                        nt     = nt + 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_mode = M_IDLE;
                tk[nt] = make_tok(ctok_pkg::KIND_END, 8'h00, n_pos, LENGTH_BITS'(0), n_line);
                nt      = nt + 1'b1;
                n_ended = 1'b1;
            end

            if (nt != '0) begin
                tk[nt - 1'b1].last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_cnt   <= '0;
            r_sline <= '0;
            r_pos   <= '0;
            r_line  <= '0;
            r_ended <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_sline <= n_sline;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_ended <= n_ended;
        end
    end

    assign o_push.n   = nt;
    assign o_push.tok = tk;

endmodule

@@ rtl/ctok_queue.sv @@
// Token queue: takes up to three items a cycle, hands out one when popped
`timescale 1ns / 1ps

module ctok_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ctok_pkg::t_push               i_push,
    input  logic                          i_pop,
    output logic                          o_valid,
    output ctok_pkg::t_tok                o_tok,
    output logic [ctok_pkg::QLVL_W-1:0]   o_level
);

    ctok_pkg::t_tok                 r_mem [ctok_pkg::QDEPTH];
    logic [ctok_pkg::QIDX_W-1:0]    r_wr;
    logic [ctok_pkg::QIDX_W-1:0]    r_rd;
    logic [ctok_pkg::QLVL_W-1:0]    r_cnt;
    logic                           pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_pop;
    assign o_tok   = r_mem[r_rd];
    assign o_level = r_cnt;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ctok_pkg::MAX_TOK; i++) begin
            if (ctok_pkg::PUSH_W'(i) < i_push.n) begin
                r_mem[ctok_pkg::QIDX_W'(r_wr + ctok_pkg::QIDX_W'(i))] <= i_push.tok[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= ctok_pkg::QIDX_W'(r_wr + ctok_pkg::QIDX_W'(i_push.n));
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= ctok_pkg::QLVL_W'(r_cnt + ctok_pkg::QLVL_W'(i_push.n)
                                       - ctok_pkg::QLVL_W'(pop));
        end
    end

endmodule

@@ rtl/c_source_tokenizer_core.sv @@
// Top level of the C source tokenizer
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_stall  i_in_data  (text_byte, final_byte)
//   out      output     o_out_valid / i_out_stall o_out_data (one token)
//
// One byte is taken per cycle unless stalled; its tokens (up to three) enter a
// four-entry queue. The queue drains one token per cycle while the output is not
// stalled, so a run of bytes giving one token each streams at full rate.
// Input stalls while the queue holds more than one token.
// Reset is synchronous and clears the lexer state and the queue.
`timescale 1ns / 1ps
`include "c_source_tokenizer_core_assert.svh"

module c_source_tokenizer_core #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ctok_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ctok_pkg::t_tok   o_out_data
);

    logic                           in_accept;
    ctok_pkg::t_push                push;
    logic [ctok_pkg::QLVL_W-1:0]    q_level;

    assign o_in_stall = (q_level > ctok_pkg::QLVL_W'(ctok_pkg::QDEPTH - ctok_pkg::MAX_TOK));
    assign in_accept  = i_in_valid && !o_in_stall;

    ctok_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_data   (i_in_data),
        .o_push   (push)
    );

    ctok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_tok   (o_out_data),
        .o_level (q_level)
    );

    `CTOK_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, 1'b1,
                     q_level <= ctok_pkg::QLVL_W'(ctok_pkg::QDEPTH))
    `CTOK_ASSERT_NOW(a_push_needs_accept, i_clk, i_rst_n, push.n != '0, in_accept)
    `CTOK_ASSERT_NOW(a_three_ends, i_clk, i_rst_n, push.n == 2'd3,
                     push.tok[2].token_kind == ctok_pkg::KIND_END)
    `CTOK_ASSERT_NOW(a_end_closes_run, i_clk, i_rst_n,
                     o_out_valid && o_out_data.token_kind == ctok_pkg::KIND_END,
                     o_out_data.last_of_run && o_out_data.token_length == '0)
    `CTOK_ASSERT_NEXT(a_no_push_after_end, i_clk, i_rst_n,
                      push.n != '0 && push.tok[push.n - 1'b1].token_kind == ctok_pkg::KIND_END,
                      push.n == '0)

endmodule
